### design/dbg_edge_label_scan_macros.svh
// ----------------------------------------------------------------------------
// dbg_edge_label_scan assertion macros
// Shared concurrent assertion forms for the edge-label scan block.
// ----------------------------------------------------------------------------
`ifndef DBG_EDGE_LABEL_SCAN_MACROS_SVH
`define DBG_EDGE_LABEL_SCAN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBGELS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DBGELS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dbgels_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbgels_pkg
// Types, constants and register codes of the edge-label scan block.
// ----------------------------------------------------------------------------
package dbgels_pkg;

    localparam int MAX_ORDER_DEF   = 20;
    localparam int SYMBOL_BITS_DEF = 3;
    localparam int COUNT_BITS_DEF  = 32;

    localparam int KMER_W      = 63;
    localparam int SYM_W_MAX   = 3;
    localparam int LABEL_W     = 4;
    localparam int TOTAL_W     = 32;
    localparam int ORDER_CFG_W = 5;
    localparam int ASZ_W       = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NODE_ORDER = 2'd0,
        CFG_MULTIGRAPH = 2'd1,
        CFG_ALPHABET   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [KMER_W-1:0] kmer_symbols;
        logic              final_kmer;
    } kmer_item_t;

    typedef struct packed {
        logic                 emits_edge;
        logic [LABEL_W-1:0]   edge_label;
        logic                 label_negated;
        logic [SYM_W_MAX-1:0] node_last_symbol;
        logic                 closes_previous_node;
        logic                 closes_latest_at_end;
        logic [TOTAL_W-1:0]   node_total;
        logic [TOTAL_W-1:0]   edge_total;
    } edge_result_t;

    // Compare unit -> scan control
    typedef struct packed {
        logic                 prefix_diff;
        logic                 suffix_diff;
        logic [SYM_W_MAX-1:0] last_sym;
        logic [SYM_W_MAX-1:0] prev_last_sym;
        logic [SYM_W_MAX-1:0] node_sym;
    } kmer_cmp_t;

endpackage

### design/dbgels_kmer_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbgels_kmer_cmp
// Per-symbol compare of the current (k+1)-mer against the previous one.
// ----------------------------------------------------------------------------
module dbgels_kmer_cmp
    import dbgels_pkg::*;
#(
    parameter int MAX_ORDER   = MAX_ORDER_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  logic [KMER_W-1:0]                          cur_raw,
    input  logic [(MAX_ORDER+1)*SYMBOL_BITS-1:0]       prev_kmer,
    input  logic [$clog2(MAX_ORDER+1)-1:0]             order_k,
    output logic [(MAX_ORDER+1)*SYMBOL_BITS-1:0]       cur_masked,
    output kmer_cmp_t                                  cmp
);

    always_comb begin
        logic [SYMBOL_BITS-1:0] sym_cur;
        logic [SYMBOL_BITS-1:0] sym_prev;
        logic                   diff;
        cur_masked = '0;
        cmp        = '0;
        for (int j = 0; j <= MAX_ORDER; j++) begin
            sym_cur  = cur_raw[j*SYMBOL_BITS +: SYMBOL_BITS];
            sym_prev = prev_kmer[j*SYMBOL_BITS +: SYMBOL_BITS];
            diff     = (sym_cur != sym_prev);
            // symbols past position k are dropped
            if (j <= int'(order_k)) begin
                cur_masked[j*SYMBOL_BITS +: SYMBOL_BITS] = sym_cur;
            end
            if (j < int'(order_k)) begin
                cmp.prefix_diff = cmp.prefix_diff | diff;
                if (j >= 1) begin
                    cmp.suffix_diff = cmp.suffix_diff | diff;
                end
            end
            if (j == int'(order_k)) begin
                cmp.last_sym      = SYM_W_MAX'(sym_cur);
                cmp.prev_last_sym = SYM_W_MAX'(sym_prev);
            end
            if (j == int'(order_k) - 1) begin
                cmp.node_sym = SYM_W_MAX'(sym_cur);
            end
        end
    end

endmodule

### design/dbg_edge_label_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbg_edge_label_scan
// Edge-label scan for succinct de Bruijn graph construction: sorted
// (k+1)-mers in, one edge-label record out per transaction.
// ----------------------------------------------------------------------------
//  channel | ports                               | dir | carries
//  --------+-------------------------------------+-----+------------------------
//  input   | s_valid, s_ready, s_data            | in  | kmer_item_t
//  result  | m_valid, m_ready, m_data            | out | edge_result_t
//  config  | cfg_valid, cfg_ready, cfg_index,    | in  | register writes
//          | cfg_wdata                           |     |
//
//  One item per clock while the result channel drains. The result of an
//  accepted item appears in the output register on the next cycle.
//  The compare against the previous (k+1)-mer, the suffix bitmap update and
//  the counter increments all sit between the scan state and the output
//  register.
//  s_ready drops only while a result is held and m_ready is low.
//  Reset (aresetn low, synchronous) restarts the stream: first item is a new
//  node, marks and counts cleared, registers back to k=20, alphabet 4.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "dbg_edge_label_scan_macros.svh"

module dbg_edge_label_scan
    import dbgels_pkg::*;
#(
    parameter int MAX_ORDER   = MAX_ORDER_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  kmer_item_t             s_data,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output edge_result_t           m_data,
    // configuration channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int KW     = (MAX_ORDER + 1) * SYMBOL_BITS;
    localparam int OW     = $clog2(MAX_ORDER + 1);
    localparam int MARK_W = 2 ** SYMBOL_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ORDER_CFG_W-1:0] node_order_reg;
    logic                   multigraph_mode_reg;
    logic [ASZ_W-1:0]       alphabet_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_order_reg      <= ORDER_CFG_W'(20);
            multigraph_mode_reg <= 1'b0;
            alphabet_size_reg   <= ASZ_W'(4);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_NODE_ORDER: node_order_reg      <= cfg_wdata[ORDER_CFG_W-1:0];
                CFG_MULTIGRAPH: multigraph_mode_reg <= cfg_wdata[0];
                CFG_ALPHABET:   alphabet_size_reg   <= cfg_wdata[ASZ_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Scan state
    // ------------------------------------------------------------------
    logic [KW-1:0]         prev_kmer_reg,    prev_kmer_next;
    logic                  first_pending_reg;
    logic [MARK_W-1:0]     marks_reg,        marks_next;
    logic [COUNT_BITS-1:0] node_counter_reg, node_counter_next;
    logic [COUNT_BITS-1:0] edge_counter_reg, edge_counter_next;

    logic         m_valid_reg;
    edge_result_t m_data_reg;
    edge_result_t result;

    logic s_accept;

    // Skid-free output register: take a new item whenever the slot is
    // empty or is being drained this cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Effective order and alphabet size (out-of-range values clamped)
    logic [OW-1:0]    order_k;
    logic [ASZ_W-1:0] asz_eff;

    always_comb begin
        if (node_order_reg == '0) begin
            order_k = OW'(1);
        end else if (node_order_reg > ORDER_CFG_W'(MAX_ORDER)) begin
            order_k = OW'(MAX_ORDER);
        end else begin
            order_k = OW'(node_order_reg);
        end
        asz_eff = (alphabet_size_reg == '0) ? ASZ_W'(1) : alphabet_size_reg;
    end

    kmer_cmp_t cmp;

    dbgels_kmer_cmp #(
        .MAX_ORDER   (MAX_ORDER),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_cmp (
        .cur_raw    (s_data.kmer_symbols),
        .prev_kmer  (prev_kmer_reg),
        .order_k    (order_k),
        .cur_masked (prev_kmer_next),
        .cmp        (cmp)
    );

    // ------------------------------------------------------------------
    // Node / edge decision, suffix bitmap, counters
    // ------------------------------------------------------------------
    always_comb begin
        logic                   new_node;
        logic                   edge_start;
        logic [MARK_W-1:0]      marks_base;
        logic [SYMBOL_BITS-1:0] mark_idx;
        logic                   hit;
        logic [LABEL_W-1:0]     label;

        new_node   = first_pending_reg || cmp.prefix_diff;
        edge_start = new_node || (cmp.last_sym != cmp.prev_last_sym) || multigraph_mode_reg;

        // bitmap restarts whenever the (k-1)-suffix moves
        marks_base = (first_pending_reg || cmp.suffix_diff) ? '0 : marks_reg;
        mark_idx   = cmp.last_sym[SYMBOL_BITS-1:0];
        hit        = marks_base[mark_idx];

        marks_next = marks_base;
        if (edge_start && !hit) begin
            marks_next[mark_idx] = 1'b1;
        end

        // negative label: add alphabet size unless already above it
        label = '0;
        if (edge_start) begin
            label = LABEL_W'(cmp.last_sym);
            if (hit && (LABEL_W'(cmp.last_sym) <= LABEL_W'(asz_eff))) begin
                label = LABEL_W'(cmp.last_sym) + LABEL_W'(asz_eff);
            end
        end

        node_counter_next = node_counter_reg;
        if (new_node && (node_counter_reg != '1)) begin
            node_counter_next = node_counter_reg + COUNT_BITS'(1);
        end
        edge_counter_next = edge_counter_reg;
        if (edge_start && (edge_counter_reg != '1)) begin
            edge_counter_next = edge_counter_reg + COUNT_BITS'(1);
        end

        result.emits_edge           = edge_start;
        result.edge_label           = label;
        result.label_negated        = edge_start && hit;
        result.node_last_symbol     = edge_start ? cmp.node_sym : '0;
        result.closes_previous_node = new_node && (edge_counter_reg != '0);
        result.closes_latest_at_end = s_data.final_kmer && (edge_counter_next != '0);
        result.node_total           = TOTAL_W'(node_counter_next);
        result.edge_total           = TOTAL_W'(edge_counter_next);
    end

    // ------------------------------------------------------------------
    // State and output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_kmer_reg     <= '0;
            first_pending_reg <= 1'b1;
            marks_reg         <= '0;
            node_counter_reg  <= '0;
            edge_counter_reg  <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (s_accept) begin
                prev_kmer_reg     <= prev_kmer_next;
                first_pending_reg <= 1'b0;
                marks_reg         <= marks_next;
                node_counter_reg  <= node_counter_next;
                edge_counter_reg  <= edge_counter_next;
                m_valid_reg       <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= result;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DBGELS_ASSERT_SAME(a_hold_blocks_input, aclk, aresetn,
        m_valid_reg && !m_ready, !s_ready, "input taken while result held")
    `DBGELS_ASSERT_NEXT(a_first_is_edge, aclk, aresetn,
        s_accept && first_pending_reg,
        m_data_reg.emits_edge && !m_data_reg.closes_previous_node,
        "first item not a fresh edge")
    `DBGELS_ASSERT_SAME(a_neg_needs_edge, aclk, aresetn,
        m_valid_reg && m_data_reg.label_negated, m_data_reg.emits_edge,
        "negated label without edge")
    `DBGELS_ASSERT_NEXT(a_edge_count_step, aclk, aresetn, s_accept,
        (edge_counter_reg == $past(edge_counter_reg)) ||
        (edge_counter_reg == $past(edge_counter_reg) + COUNT_BITS'(1)),
        "edge count jumped")

endmodule
